// ----- src/odiff_pkg.sv -----
// Shared types, widths and codes for the offset difference stream block.
package odiff_pkg;

	localparam int SAMPLE_W = 16;
	localparam int VALUE_W  = 18;
	localparam int POS_W    = 24;
	localparam int LEN_W    = 24;
	localparam int CNT_W    = 25;
	localparam int OFF_W    = 13;
	localparam int MODE_W   = 2;
	localparam int IDX_W    = 2;
	localparam int CFG_W    = 24;
	localparam int OUT_W    = 48;

	// mode register codes; the unused code runs as first difference
	typedef enum logic [MODE_W-1:0] {
		MODE_DIFF   = 2'd0,
		MODE_SECOND = 2'd1,
		MODE_SUM    = 2'd2
	} mode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_MODE   = 2'd0,
		REG_OFFSET = 2'd1,
		REG_LENGTH = 2'd2
	} reg_idx_t;

	// arithmetic selected per item
	typedef enum logic [2:0] {
		OP_ZERO   = 3'd0,
		OP_COPY   = 3'd1,
		OP_DIFF   = 3'd2,
		OP_SUM    = 3'd3,
		OP_SECOND = 3'd4
	} op_t;

	// effective configuration
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [OFF_W-1:0]  off;       // clamped to MAX_OFFSET
		logic [LEN_W-1:0]  len;       // zero taken as one
		logic [CNT_W-1:0]  span;      // len + off
		logic              short_img; // 2*off > len
	} cfg_t;

	// per-item decision from the sequencer
	typedef struct packed {
		logic             emit;
		logic             store;
		op_t              op;
		logic [POS_W-1:0] pos;
		logic             last;
	} item_ctl_t;

endpackage

// ----- src/odiff_cfg.sv -----
// Configuration registers and derived effective settings.
module odiff_cfg #(
	parameter int MAX_OFFSET = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [odiff_pkg::IDX_W-1:0] cfg_index,
	input  logic [odiff_pkg::CFG_W-1:0] cfg_wdata,
	output odiff_pkg::cfg_t             cfg,
	output logic                        restart
);

	logic [odiff_pkg::MODE_W-1:0] mode_q;
	logic [odiff_pkg::OFF_W-1:0]  off_q;
	logic [odiff_pkg::LEN_W-1:0]  len_q;
	logic [odiff_pkg::OFF_W-1:0]  off_eff;
	logic [odiff_pkg::LEN_W-1:0]  len_eff;
	logic                         hit;

	always_comb begin
		hit = 1'b0;
		unique case (cfg_index)
			odiff_pkg::REG_MODE,
			odiff_pkg::REG_OFFSET,
			odiff_pkg::REG_LENGTH: hit = 1'b1;
			default:               hit = 1'b0;
		endcase
	end

	assign restart = cfg_wen && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= odiff_pkg::MODE_DIFF;
			off_q  <= odiff_pkg::OFF_W'(1);
			len_q  <= odiff_pkg::LEN_W'(1);
		end else if (cfg_wen) begin
			unique case (cfg_index)
				odiff_pkg::REG_MODE:   mode_q <= cfg_wdata[odiff_pkg::MODE_W-1:0];
				odiff_pkg::REG_OFFSET: off_q  <= cfg_wdata[odiff_pkg::OFF_W-1:0];
				odiff_pkg::REG_LENGTH: len_q  <= cfg_wdata[odiff_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		off_eff = (32'(off_q) > 32'(MAX_OFFSET)) ? odiff_pkg::OFF_W'(MAX_OFFSET) : off_q;
		len_eff = (len_q == '0) ? odiff_pkg::LEN_W'(1) : len_q;
		cfg.mode      = mode_q;
		cfg.off       = off_eff;
		cfg.len       = len_eff;
		cfg.span      = {1'b0, len_eff} + odiff_pkg::CNT_W'(off_eff);
		cfg.short_img = odiff_pkg::LEN_W'({off_eff, 1'b0}) > len_eff;
	end

endmodule

// ----- src/odiff_delay.sv -----
// Sample delay memory: one write port, two registered read ports.
module odiff_delay #(
	parameter int DEPTH = 8192,
	parameter int AW    = 13
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [AW-1:0]                         wr_addr,
	input  logic signed [odiff_pkg::SAMPLE_W-1:0] wr_data,
	input  logic                                  rd_en,
	input  logic [AW-1:0]                         near_addr,
	input  logic [AW-1:0]                         far_addr,
	output logic signed [odiff_pkg::SAMPLE_W-1:0] near_s1,
	output logic signed [odiff_pkg::SAMPLE_W-1:0] far_s1
);

	logic signed [odiff_pkg::SAMPLE_W-1:0] mem [DEPTH];

	// read returns old data on an address collision (full-depth lookback)
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			near_s1 <= mem[near_addr];
			far_s1  <= mem[far_addr];
		end
	end

endmodule

// ----- src/odiff_seq.sv -----
// Item counter, write pointer and per-item decision logic.
module odiff_seq #(
	parameter int DEPTH = 8192,
	parameter int AW    = 13
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  odiff_pkg::cfg_t       cfg,
	input  logic                  restart,
	input  logic                  accept,
	input  logic                  drain,
	output odiff_pkg::item_ctl_t  ctl,
	output logic [AW-1:0]         wr_addr,
	output logic [AW-1:0]         near_addr,
	output logic [AW-1:0]         far_addr
);

	localparam int CW = AW + 1;

	logic [odiff_pkg::CNT_W-1:0] cnt_q;
	logic [AW-1:0]               wp_q;
	logic [odiff_pkg::CNT_W-1:0] lim, c, c_inc, nxt, q, off_ext;
	logic                        mode1, in_img, act, near_ok, far_ok;
	logic [CW-1:0]               wp_ext, k_near, k_far;

	always_comb begin
		mode1   = (cfg.mode == odiff_pkg::MODE_SECOND);
		off_ext = odiff_pkg::CNT_W'(cfg.off);
		lim     = mode1 ? cfg.span : {1'b0, cfg.len};
		c       = (cnt_q >= lim) ? '0 : cnt_q;
		c_inc   = c + odiff_pkg::CNT_W'(1);
		nxt     = (c_inc >= lim) ? '0 : c_inc;
		in_img  = !mode1 || (c < {1'b0, cfg.len});
		act     = !(drain && in_img);   // stray drains leave state alone
		q       = c - off_ext;
		near_ok = (c >= off_ext);
		far_ok  = in_img && !cfg.short_img && (q >= off_ext);

		ctl.emit  = act && (!mode1 || near_ok);
		ctl.store = act && in_img;
		if (cfg.off == '0)
			ctl.op = odiff_pkg::OP_COPY;
		else if (mode1)
			ctl.op = far_ok ? odiff_pkg::OP_SECOND : odiff_pkg::OP_ZERO;
		else if (near_ok)
			ctl.op = (cfg.mode == odiff_pkg::MODE_SUM) ? odiff_pkg::OP_SUM : odiff_pkg::OP_DIFF;
		else
			ctl.op = odiff_pkg::OP_ZERO;
		ctl.pos  = mode1 ? q[odiff_pkg::POS_W-1:0] : c[odiff_pkg::POS_W-1:0];
		ctl.last = (ctl.pos == cfg.len - odiff_pkg::LEN_W'(1));
	end

	// circular lookback addresses
	always_comb begin
		wp_ext    = {1'b0, wp_q};
		k_near    = CW'(cfg.off);
		k_far     = CW'({cfg.off, 1'b0});
		near_addr = AW'((wp_ext >= k_near) ? wp_ext - k_near : wp_ext + CW'(DEPTH) - k_near);
		far_addr  = AW'((wp_ext >= k_far) ? wp_ext - k_far : wp_ext + CW'(DEPTH) - k_far);
	end

	assign wr_addr = wp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= '0;
		end else if (restart) begin
			cnt_q <= '0;
			wp_q  <= '0;
		end else if (accept && act) begin
			cnt_q <= nxt;
			if (ctl.store) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
		end
	end

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		restart |=> (cnt_q == '0) && (wp_q == '0))
		else $error("counter or pointer not cleared by register write");

	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= AW'(DEPTH - 1))
		else $error("write pointer beyond delay depth");

endmodule

// ----- src/offset_difference_stream_top.sv -----
// Top level of the offset difference stream block.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-------------------------------------------
//  s_*     | in  | s_tvalid/s_tready | s_tdata: sample[15:0]; s_tuser: kind
//  m_*     | out | m_tvalid/m_tready | m_tdata: value[17:0], position[41:18]; m_tlast
//  cfg_*   | in  | cfg_wen           | cfg_index, cfg_wdata (no read-back)
//
// One item per cycle sustained while the output is not stalled. Once the item that
// produces it is taken, a result passes stage one, which reads both lookback taps of
// the delay memory, then stage two, which does the add and fills the output register.
// In second-difference mode a result is produced by the item off positions later.
// Reset clears counter, pointer, valids and configuration registers; the memory is not cleared.
// A stall on m_tready holds the output; input is still taken while stage one is free.
module offset_difference_stream_top #(
	parameter int MAX_OFFSET = 4096
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// stream in
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [odiff_pkg::SAMPLE_W-1:0]        s_tdata,   // [15:0] sample
	input  logic                                  s_tuser,   // [0] kind (1 = drain)
	// stream out
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [odiff_pkg::OUT_W-1:0]           m_tdata,   // [17:0] value, [41:18] position
	output logic                                  m_tlast,
	// configuration writes
	input  logic                                  cfg_wen,
	input  logic [odiff_pkg::IDX_W-1:0]           cfg_index,
	input  logic [odiff_pkg::CFG_W-1:0]           cfg_wdata
);

	localparam int DEPTH = 2 * MAX_OFFSET;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	odiff_pkg::cfg_t      cfg;
	odiff_pkg::item_ctl_t ctl;
	logic                 restart;
	logic                 accept, out_en, s1_en;
	logic [AW-1:0]        wr_addr, near_addr, far_addr;

	// stage one
	logic                                  valid_s1;
	odiff_pkg::op_t                        op_s1;
	logic [odiff_pkg::POS_W-1:0]           pos_s1;
	logic                                  last_s1;
	logic signed [odiff_pkg::SAMPLE_W-1:0] x_s1, near_s1, far_s1;

	// output register
	logic                                  out_valid_q;
	logic signed [odiff_pkg::VALUE_W-1:0]  value_q;
	logic [odiff_pkg::POS_W-1:0]           pos_q;
	logic                                  last_q;

	logic signed [odiff_pkg::VALUE_W-1:0]  xe, ne, fe, value_d;

	// pipeline flow: each stage moves when the one after it has room
	assign out_en   = !out_valid_q || m_tready;
	assign s1_en    = !valid_s1 || out_en;
	assign s_tready = s1_en;
	assign accept   = s_tvalid && s1_en;

	odiff_cfg #(.MAX_OFFSET(MAX_OFFSET)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg),
		.restart   (restart)
	);

	odiff_seq #(.DEPTH(DEPTH), .AW(AW)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.restart   (restart),
		.accept    (accept),
		.drain     (s_tuser),
		.ctl       (ctl),
		.wr_addr   (wr_addr),
		.near_addr (near_addr),
		.far_addr  (far_addr)
	);

	odiff_delay #(.DEPTH(DEPTH), .AW(AW)) u_delay (
		.clk       (clk),
		.wr_en     (accept && ctl.store),
		.wr_addr   (wr_addr),
		.wr_data   (s_tdata),
		.rd_en     (accept),
		.near_addr (near_addr),
		.far_addr  (far_addr),
		.near_s1   (near_s1),
		.far_s1    (far_s1)
	);

	// stage one: decision and sample, taps arrive from the memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_en) begin
			valid_s1 <= accept && ctl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= ctl.op;
			pos_s1  <= ctl.pos;
			last_s1 <= ctl.last;
			x_s1    <= s_tdata;
		end
	end

	// stage two arithmetic, exact in 18 bits
	always_comb begin
		xe = {{2{x_s1[odiff_pkg::SAMPLE_W-1]}}, x_s1};
		ne = {{2{near_s1[odiff_pkg::SAMPLE_W-1]}}, near_s1};
		fe = {{2{far_s1[odiff_pkg::SAMPLE_W-1]}}, far_s1};
		case (op_s1)
			odiff_pkg::OP_COPY:   value_d = xe;
			odiff_pkg::OP_DIFF:   value_d = xe - ne;
			odiff_pkg::OP_SUM:    value_d = xe + ne;
			odiff_pkg::OP_SECOND: value_d = (ne <<< 1) - xe - fe;
			default:              value_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_en) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && valid_s1) begin
			value_q <= value_d;
			pos_q   <= pos_s1;
			last_q  <= last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(odiff_pkg::OUT_W - odiff_pkg::POS_W - odiff_pkg::VALUE_W){1'b0}},
		pos_q, value_q};
	assign m_tlast  = last_q;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("input blocked while output register empty");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_en) |=> valid_s1 && $stable(pos_s1) && $stable(op_s1))
		else $error("stage one item lost during stall");

endmodule

// ----- sim/tb.sv -----
// Testbench for offset_difference_stream_top: predicting scoreboard, directed and random items.
`timescale 1ns / 1ps

module tb;

	localparam int MAX_OFF       = 4096;
	localparam int STORE_DEPTH   = 2 * MAX_OFF;
	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 11;
	localparam int SETTLE_CYCLES = 8;      // two pipe stages plus margin
	localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
	localparam int QUIET_LIMIT   = 5000;   // cycles with no handshake before giving up
	localparam int RANDOM_ITEMS  = 920;
	localparam logic [odiff_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;   // runs as first difference

	// Tracks configuration, item counter and sample history; predicts each result.
	class offset_diff_scoreboard;
		typedef struct {
			logic signed [odiff_pkg::VALUE_W-1:0] value;
			logic [odiff_pkg::POS_W-1:0]          position;
			logic                                 last;
		} diff_result_t;

		logic signed [odiff_pkg::SAMPLE_W-1:0] sample_hist [STORE_DEPTH];
		int unsigned                           item_count;
		int unsigned                           write_ptr;
		logic [odiff_pkg::MODE_W-1:0]          mode_reg;
		logic [odiff_pkg::OFF_W-1:0]           offset_reg;
		logic [odiff_pkg::LEN_W-1:0]           length_reg;
		diff_result_t                          pending_results [$];
		int                                    errors;
		int                                    matched;

		function new();
			mode_reg   = odiff_pkg::MODE_DIFF;
			offset_reg = odiff_pkg::OFF_W'(1);
			length_reg = odiff_pkg::LEN_W'(1);
			item_count = 0;
			write_ptr  = 0;
			errors     = 0;
			matched    = 0;
		endfunction

		function int unsigned eff_off();
			return (offset_reg > MAX_OFF) ? MAX_OFF : offset_reg;
		endfunction

		function int unsigned eff_len();
			return (length_reg == 0) ? 1 : length_reg;
		endfunction

		// second-difference tail: items past the image only push out results
		function bit in_flush();
			return mode_reg == odiff_pkg::MODE_SECOND && item_count >= eff_len();
		endfunction

		function void write_reg(odiff_pkg::reg_idx_t idx, logic [odiff_pkg::CFG_W-1:0] val);
			case (idx)
				odiff_pkg::REG_MODE: begin
					mode_reg = val[odiff_pkg::MODE_W-1:0];
				end
				odiff_pkg::REG_OFFSET: begin
					offset_reg = val[odiff_pkg::OFF_W-1:0];
				end
				odiff_pkg::REG_LENGTH: begin
					length_reg = val[odiff_pkg::LEN_W-1:0];
				end
				default: begin
					return;
				end
			endcase
			// any write to a defined register restarts the image
			item_count = 0;
			write_ptr  = 0;
		endfunction

		function int sample_back(int unsigned k);
			int unsigned idx;
			idx = (write_ptr >= k) ? write_ptr - k : write_ptr + STORE_DEPTH - k;
			return int'(sample_hist[idx]);
		endfunction

		function void push_sample(logic signed [odiff_pkg::SAMPLE_W-1:0] x);
			sample_hist[write_ptr] = x;
			write_ptr = (write_ptr + 1) % STORE_DEPTH;
		endfunction

		function void add_result(int v, int unsigned pos, int unsigned len);
			diff_result_t r;
			r.value    = v[odiff_pkg::VALUE_W-1:0];
			r.position = pos[odiff_pkg::POS_W-1:0];
			r.last     = (pos == len - 1);
			pending_results.push_back(r);
		endfunction

		// Notes one accepted item; returns 0 when the block ignores it.
		function bit take_item(bit drain, logic [odiff_pkg::SAMPLE_W-1:0] smp);
			logic signed [odiff_pkg::SAMPLE_W-1:0] x;
			int unsigned off, len, c, span, q;
			int v;
			bit in_img;
			x   = smp;
			off = eff_off();
			len = eff_len();
			c   = item_count;
			v   = 0;
			if (mode_reg != odiff_pkg::MODE_SECOND) begin
				if (drain)
					return 0;
				if (c >= len)
					c = 0;
				if (off == 0)
					v = x;
				else if (c >= off)
					v = (mode_reg == odiff_pkg::MODE_SUM) ? x + sample_back(off)
						: x - sample_back(off);
				push_sample(x);
				item_count = (c + 1 >= len) ? 0 : c + 1;
				add_result(v, c, len);
				return 1;
			end
			span   = len + off;
			in_img = c < len;
			if (c >= span) begin
				c      = 0;
				in_img = 1;
			end
			if (in_img && drain)
				return 0;
			// result for position c-off leaves with this item
			if (c >= off) begin
				q = c - off;
				if (off == 0)
					v = x;
				else if (in_img && 2 * off <= len && q >= off)
					v = 2 * sample_back(off) - x - sample_back(2 * off);
				add_result(v, q, len);
			end
			if (in_img)
				push_sample(x);
			item_count = (c + 1 >= span) ? 0 : c + 1;
			return 1;
		endfunction

		function void check_result(logic [odiff_pkg::OUT_W-1:0] data, logic tlast);
			diff_result_t                         want;
			logic signed [odiff_pkg::VALUE_W-1:0] got_value;
			logic [odiff_pkg::POS_W-1:0]          got_pos;
			got_value = data[odiff_pkg::VALUE_W-1:0];
			got_pos   = data[odiff_pkg::VALUE_W +: odiff_pkg::POS_W];
			if (pending_results.size() == 0) begin
				$error("result with nothing pending: value %0d position %0d",
					got_value, got_pos);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got_value !== want.value) begin
				$error("value: expected %0d, got %0d", want.value, got_value);
				errors++;
			end
			if (got_pos !== want.position) begin
				$error("position: expected %0d, got %0d", want.position, got_pos);
				errors++;
			end
			if (tlast !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, tlast);
				errors++;
			end
			matched++;
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [odiff_pkg::SAMPLE_W-1:0] s_tdata;   // [15:0] sample
	logic                           s_tuser;   // [0] kind (1 = drain)
	logic                           m_tvalid;
	logic                           m_tready;
	logic [odiff_pkg::OUT_W-1:0]    m_tdata;   // [17:0] value, [41:18] position
	logic                           m_tlast;
	logic                           cfg_wen;
	logic [odiff_pkg::IDX_W-1:0]    cfg_index;
	logic [odiff_pkg::CFG_W-1:0]    cfg_wdata;

	offset_diff_scoreboard sb;
	int  send_gap_pct;
	int  recv_gap_pct;
	bit  hold_req;
	int  live_items;
	int  n_configs;
	int  quiet = 0;

	offset_difference_stream_top #(
		.MAX_OFFSET(MAX_OFF)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// results are checked at the edge that takes them
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tlast);
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		bit hold_taken;
		hold_taken = 1'b0;
		m_tready   = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				m_tready   = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_tready = ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// watchdog: too long without any handshake ends the run
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("tb: timeout, %0d results still pending", sb.pending_results.size());
			$display("tb: done, errors");
			$finish;
		end
	end

	function automatic logic [odiff_pkg::SAMPLE_W-1:0] pick_sample();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return r[odiff_pkg::SAMPLE_W-1:0];
		endcase
	endfunction

	// Offers one item from a falling edge until it is taken; may idle first.
	task automatic send_item(bit drain, logic [odiff_pkg::SAMPLE_W-1:0] smp);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = drain;
		s_tdata  = smp;
		do
			@(posedge clk);
		while (!s_tready);
		if (sb.take_item(drain, smp))
			live_items++;
		@(negedge clk);
	endtask

	task automatic wait_results();
		s_tvalid = 1'b0;
		while (sb.pending_results.size() != 0)
			@(negedge clk);
	endtask

	// idle before a register write: results out, pipe empty
	task automatic settle();
		wait_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(odiff_pkg::reg_idx_t idx, logic [odiff_pkg::CFG_W-1:0] val);
		cfg_wen   = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_wen = 1'b0;
		sb.write_reg(idx, val);
	endtask

	task automatic configure(logic [odiff_pkg::MODE_W-1:0] m, logic [odiff_pkg::OFF_W-1:0] o,
			logic [odiff_pkg::LEN_W-1:0] l);
		settle();
		write_reg(odiff_pkg::REG_MODE, odiff_pkg::CFG_W'(m));
		write_reg(odiff_pkg::REG_OFFSET, odiff_pkg::CFG_W'(o));
		write_reg(odiff_pkg::REG_LENGTH, odiff_pkg::CFG_W'(l));
		n_configs++;
	endtask

	// Sends n non-ignored items; drains mostly in the tail window, some stray.
	task automatic run_items(int unsigned n, int pause_at);
		int unsigned done;
		int          prev_live;
		bit          drain;
		done = 0;
		while (done < n) begin
			if (int'(done) == pause_at) begin
				wait_results();
				pause_at = -1;
			end
			if (sb.in_flush())
				drain = ($urandom_range(9) != 0);
			else
				drain = ($urandom_range(19) == 0);
			prev_live = live_items;
			send_item(drain, pick_sample());
			done += live_items - prev_live;
		end
	endtask

	initial begin
		logic [odiff_pkg::MODE_W-1:0] m;
		logic [odiff_pkg::OFF_W-1:0]  o;
		logic [odiff_pkg::LEN_W-1:0]  l;
		int unsigned                  unit, n, eo, el;
		int                           start_items;
		bit                           pause_done, hold_done;

		sb           = new();
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = 1'b0;
		cfg_wen      = 1'b0;
		cfg_index    = odiff_pkg::REG_MODE;
		cfg_wdata    = '0;
		send_gap_pct = 24;
		recv_gap_pct = 77;
		hold_req     = 1'b0;
		live_items   = 0;
		n_configs    = 0;
		pause_done   = 0;
		hold_done    = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// first difference at both sample extremes, boundary zeros, stray drain
		configure(odiff_pkg::MODE_DIFF, 13'd2, 24'd5);
		send_item(1'b0, 16'h7fff);
		send_item(1'b0, 16'h8000);
		send_item(1'b0, 16'h8000);
		send_item(1'b0, 16'h7fff);
		send_item(1'b1, 16'h1234);
		send_item(1'b0, 16'hffff);
		// zero length taken as one, offset zero copies
		configure(odiff_pkg::MODE_SUM, 13'd0, 24'd0);
		send_item(1'b0, 16'h8000);
		send_item(1'b0, 16'h7fff);
		// unused mode code, offset above the clamp; image cut short by next write
		configure(MODE_UNUSED, 13'h1fff, 24'd3);
		send_item(1'b0, 16'h0001);
		send_item(1'b0, 16'h0002);
		// sum extremes
		configure(odiff_pkg::MODE_SUM, 13'd1, 24'd4);
		send_item(1'b0, 16'h8000);
		send_item(1'b0, 16'h8000);
		send_item(1'b0, 16'h7fff);
		send_item(1'b0, 16'h7fff);
		// second difference: stray drain, full-scale swings, sample in the tail
		configure(odiff_pkg::MODE_SECOND, 13'd1, 24'd4);
		send_item(1'b1, 16'h0000);
		send_item(1'b0, 16'h7fff);
		send_item(1'b0, 16'h8000);
		send_item(1'b0, 16'h7fff);
		send_item(1'b0, 16'h8000);
		send_item(1'b0, 16'h5555);
		// image shorter than twice the offset: all zeros, normal timing
		configure(odiff_pkg::MODE_SECOND, 13'd2, 24'd3);
		send_item(1'b0, 16'h7fff);
		send_item(1'b0, 16'h8000);
		send_item(1'b0, 16'h7fff);
		send_item(1'b1, 16'h0000);
		send_item(1'b1, 16'h0000);

		// random configurations with whole images, partial images and noise
		start_items = live_items;
		while (live_items - start_items < RANDOM_ITEMS) begin
			case ($urandom_range(9))
				0, 1, 2: m = odiff_pkg::MODE_DIFF;
				3, 4:    m = odiff_pkg::MODE_SUM;
				9:       m = MODE_UNUSED;
				default: m = odiff_pkg::MODE_SECOND;
			endcase
			case ($urandom_range(9))
				0: o = 13'd0;
				1: o = (m == odiff_pkg::MODE_SECOND) ? 13'd1 : 13'h1fff;
				default: o = odiff_pkg::OFF_W'($urandom_range(1, 5));
			endcase
			case ($urandom_range(9))
				0: l = 24'd0;
				1: l = 24'd1;
				default: l = odiff_pkg::LEN_W'($urandom_range(2, 24));
			endcase
			eo   = (o > MAX_OFF) ? MAX_OFF : o;
			el   = (l == 0) ? 1 : l;
			unit = (m == odiff_pkg::MODE_SECOND) ? el + eo : el;
			n    = $urandom_range(1, 3) * unit;
			if ($urandom_range(3) == 0)
				n += $urandom_range(0, unit - 1);
			configure(m, o, l);
			// idling pattern moves through three regimes over the random part
			if (live_items - start_items < RANDOM_ITEMS / 3) begin
				send_gap_pct = 24;
				recv_gap_pct = 77;
			end else if (live_items - start_items < 2 * RANDOM_ITEMS / 3) begin
				send_gap_pct = 77;
				recv_gap_pct = 24;
			end else begin
				send_gap_pct = 0;
				recv_gap_pct = 0;
			end
			if (send_gap_pct == 0 && !hold_done) begin
				// receiver stalls long while items keep coming: input must back up
				hold_req  = 1'b1;
				hold_done = 1;
				n += 20;
			end
			if (send_gap_pct == 77 && !pause_done && n > 1) begin
				pause_done = 1;
				run_items(n, n / 2);
			end else begin
				run_items(n, -1);
			end
		end

		// longest images, run without idling
		send_gap_pct = 0;
		recv_gap_pct = 0;
		configure(odiff_pkg::MODE_SUM, 13'd5, 24'hffffff);
		run_items(40, -1);
		configure(odiff_pkg::MODE_SECOND, 13'd3, 24'hffffff);
		run_items(30, -1);

		settle();
		$display("tb: %0d items taken, %0d results checked, %0d register settings",
			live_items, sb.matched, n_configs);
		$display("tb: every mode code, offsets 0..5 and clamped, lengths 0..2^24-1");
		if (sb.errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

// ----- files.f -----
src/odiff_pkg.sv
src/odiff_cfg.sv
src/odiff_delay.sv
src/odiff_seq.sv
src/offset_difference_stream_top.sv
sim/tb.sv
